// ----- rtl/bdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, digit counts, the ASCII base code and the control state encoding.
// ----------------------------------------------------------------------------
package bdc_pkg;

  // width of the input word as it appears on the channel
  localparam int NUM_WIDTH   = 64;
  // low bits of the input word that take part in the conversion
  localparam int VALUE_WIDTH = 64;
  // ascii code width on the output channel
  localparam int CHAR_WIDTH  = 6;
  // decimal digits needed for the widest value
  localparam int MAX_DIGITS  = 20;
  localparam int BCD_WIDTH   = 4 * MAX_DIGITS;

  // counter widths
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  // ascii '0' reduced to the character width
  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_STRIP,
    ST_EMIT
  } bdc_state_t;

endpackage

// ----- rtl/bdc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdc_if: valid/ready channels of the binary to decimal ASCII converter
// bdc_num_if carries binary values in, bdc_char_if carries digit characters out.
// ----------------------------------------------------------------------------
interface bdc_num_if;
  logic                          valid;
  logic                          ready;
  logic [bdc_pkg::NUM_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface bdc_char_if;
  logic                           valid;
  logic                           ready;
  logic [bdc_pkg::CHAR_WIDTH-1:0] digit_char;
  logic                           last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- rtl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII text
// Usage:
//   num  : sink channel, one word is an unsigned value (low VALUE_WIDTH bits
//          are used, higher bits are ignored)
//   chr  : source channel, one word per decimal digit, most significant first,
//          no leading zeros; last_digit marks the final digit of a value;
//          a zero value gives the single character '0'
// Timing:
//   a value is accepted while idle, converted by bit-serial shift-and-add-3
//   (double dabble) into a 20-digit BCD shift register, stripped of leading
//   zeros one digit at a time, then sent one digit per cycle while chr.ready
//   is high; num.ready is high only between values.
// Reset:
//   rst (synchronous) returns the block to idle and drops any value in work.
// Stalls:
//   while chr.ready is low the current digit is held on chr and the block
//   waits; no digit is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic              clk,
  input  logic              rst,
  bdc_num_if.sink           num,
  bdc_char_if.source        chr
);
  import bdc_pkg::*;

  bdc_state_t               state, state_next;
  logic [VALUE_WIDTH-1:0]   bin, bin_next;
  logic [BCD_WIDTH-1:0]     bcd, bcd_next;
  logic [BCD_WIDTH-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0]     bit_cnt, bit_cnt_next;
  logic [DIGIT_CNT_W-1:0]   dig_cnt, dig_cnt_next;
  logic [3:0]               top_digit;

  assign top_digit = bcd[BCD_WIDTH-1 -: 4];

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    logic [3:0] nib;
    nib = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      nib = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      dig_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
      dig_cnt <= dig_cnt_next;
    end
    bin <= bin_next;
    bcd <= bcd_next;
  end

  // next state and datapath control
  always_comb begin
    state_next   = state;
    bin_next     = bin;
    bcd_next     = bcd;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    case (state)
      ST_IDLE: begin
        if (num.valid) begin
          bin_next     = num.number[VALUE_WIDTH-1:0];
          bcd_next     = '0;
          bit_cnt_next = '0;
          state_next   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        bcd_next     = {bcd_adj[BCD_WIDTH-2:0], bin[VALUE_WIDTH-1]};
        bin_next     = {bin[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
          dig_cnt_next = DIGIT_CNT_W'(MAX_DIGITS);
          state_next   = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // drop leading zeros, always keep the final digit
        if (top_digit == 4'd0 && dig_cnt != DIGIT_CNT_W'(1)) begin
          bcd_next     = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (chr.ready) begin
          bcd_next     = {bcd[BCD_WIDTH-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
          if (dig_cnt == DIGIT_CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // channel outputs
  assign num.ready      = (state == ST_IDLE);
  assign chr.valid      = (state == ST_EMIT);
  assign chr.digit_char = ASCII_ZERO | {{(CHAR_WIDTH-4){1'b0}}, top_digit};
  assign chr.last_digit = (dig_cnt == DIGIT_CNT_W'(1));

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the binary to decimal ASCII converter
// Binary values go in on the num channel. Every accepted value is turned into
// its expected run of decimal digit characters, most significant first.
// Each character word on the chr channel is checked against the oldest
// expected character. Both channels idle at random, and one long receiver
// hold-off backs the converter up until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import bdc_pkg::*;

  localparam logic [NUM_WIDTH-1:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] digit_char;
    logic                  last_digit;
  } char_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bdc_num_if  num_ch ();
  bdc_char_if chr_ch ();

  binary_to_decimal_ascii i_dut (
    .clk (clk),
    .rst (rst),
    .num (num_ch),
    .chr (chr_ch)
  );

  logic [NUM_WIDTH-1:0] pending_numbers[$];
  char_word_t           expected_chars[$];
  int                   error_count   = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   phase         = 0;
  logic                 num_fire      = 1'b0;
  logic                 hold_active   = 1'b0;

  // clock
  always #5 clk = ~clk;

  // known values on all inputs from the start
  initial begin
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    chr_ch.ready  = 1'b0;
  end

  // reset, released at a falling edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // expected characters of one value, most significant digit first
  task automatic push_decimal_chars(input logic [NUM_WIDTH-1:0] value);
    logic [NUM_WIDTH-1:0] rest;
    logic [3:0]           rev_digits[MAX_DIGITS];
    int                   count;
    char_word_t           w;
    rest  = value & VALUE_MASK;
    count = 0;
    do begin
      rev_digits[count] = 4'(rest % 64'd10);
      rest = rest / 64'd10;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      w.digit_char = ASCII_ZERO + CHAR_WIDTH'(rev_digits[count-1-k]);
      w.last_digit = (k == count - 1);
      expected_chars.push_back(w);
    end
  endtask

  // input driver: a new word only once the current one has been taken
  always @(negedge clk) begin
    if (rst) begin
      num_ch.valid <= 1'b0;
    end else if (!num_ch.valid || num_fire) begin
      if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        num_ch.number <= pending_numbers.pop_front();
        num_ch.valid  <= 1'b1;
      end else begin
        num_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready, forced low during the hold-off
  always @(negedge clk) begin
    chr_ch.ready <= !rst && !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    wait (phase == 1);
    @(negedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active <= 1'b0;
  end

  // monitor: predict on accepted values, check accepted characters
  always @(posedge clk) begin
    char_word_t want;
    num_fire <= !rst && num_ch.valid && num_ch.ready;
    if (!rst && chr_ch.valid && chr_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected digit word char=%0d last=%0b", $time,
                 chr_ch.digit_char, chr_ch.last_digit);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (chr_ch.digit_char !== want.digit_char) begin
          $display("%0t: digit_char mismatch expected=%0d actual=%0d", $time,
                   want.digit_char, chr_ch.digit_char);
          error_count++;
        end
        if (chr_ch.last_digit !== want.last_digit) begin
          $display("%0t: last_digit mismatch expected=%0b actual=%0b", $time,
                   want.last_digit, chr_ch.last_digit);
          error_count++;
        end
      end
    end
    if (!rst && num_ch.valid && num_ch.ready) begin
      push_decimal_chars(num_ch.number);
    end
  end

  // power of ten, 10**e for e up to 19
  function automatic logic [NUM_WIDTH-1:0] pow10(input int e);
    logic [NUM_WIDTH-1:0] p;
    p = 64'd1;
    for (int i = 0; i < e; i++) p = p * 64'd10;
    return p;
  endfunction

  // random value: mostly spread over all digit counts, some near decades
  function automatic logic [NUM_WIDTH-1:0] random_number();
    logic [NUM_WIDTH-1:0] v;
    int                   pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      v = {$urandom, $urandom} >> $urandom_range(63);
    end else if (pick < 80) begin
      v = {$urandom, $urandom};
    end else if (pick < 95) begin
      v = pow10($urandom_range(19)) + NUM_WIDTH'($urandom_range(4)) - 64'd2;
    end else begin
      v = NUM_WIDTH'($urandom_range(9));
    end
    return v;
  endfunction

  task automatic wait_until_drained();
    while (pending_numbers.size() != 0 || num_ch.valid || expected_chars.size() != 0)
      @(posedge clk);
  endtask

  // stimulus and end of run
  initial begin
    while (rst) @(posedge clk);

    // phase 0: directed corners, then random with a busy receiver
    @(posedge clk);
    send_idle_pct = 8;
    recv_idle_pct = 46;
    pending_numbers.push_back(64'd0);
    pending_numbers.push_back(64'd1);
    pending_numbers.push_back(64'd9);
    pending_numbers.push_back(64'd10);
    pending_numbers.push_back(64'd99);
    pending_numbers.push_back(64'd100);
    pending_numbers.push_back(64'd101);
    pending_numbers.push_back(64'd255);
    pending_numbers.push_back(64'hFFFF_FFFF);
    pending_numbers.push_back(64'h1_0000_0000);
    pending_numbers.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_numbers.push_back(64'h8000_0000_0000_0000);
    pending_numbers.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_numbers.push_back(64'hFFFF_FFFF_FFFF_FFFE);
    pending_numbers.push_back(64'h5555_5555_5555_5555);
    pending_numbers.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_numbers.push_back(64'd10000000000000000000);
    pending_numbers.push_back(64'd9999999999999999999);
    pending_numbers.push_back(64'd12345678901234567890);
    pending_numbers.push_back(64'd1000000000);
    pending_numbers.push_back(64'd9080706050403020100);
    pending_numbers.push_back(64'd0);
    repeat (100) pending_numbers.push_back(random_number());
    wait_until_drained();

    // phase 1: gappy sender, long receiver hold-off backs the block up
    @(posedge clk);
    send_idle_pct = 46;
    recv_idle_pct = 8;
    repeat (115) pending_numbers.push_back(random_number());
    phase = 1;
    wait_until_drained();

    // phase 2: full rate on both sides
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase = 2;
    repeat (115) pending_numbers.push_back(random_number());
    wait_until_drained();

    // let any stray word show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout with %0d digit words outstanding", expected_chars.size());
    $display("tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bdc_pkg.sv
rtl/bdc_if.sv
rtl/binary_to_decimal_ascii.sv
tb/sv/tb.sv
